// ===== design/polar_scan_to_transformed_point_macros.svh =====
// assertion helpers shared by the point pipeline
`ifndef POLAR_SCAN_TO_TRANSFORMED_POINT_MACROS_SVH
`define POLAR_SCAN_TO_TRANSFORMED_POINT_MACROS_SVH

// same-cycle implication
`define PSTP_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define PSTP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/pstp_pkg.sv =====
package pstp_pkg;

    // scan geometry and rotator depth
    localparam int INDEX_BITS    = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_DEPTH    = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;

    // datapath widths
    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int XY_W     = 33;
    localparam int PROJ_W   = RANGE_W + 1 + XY_W;
    localparam int PX_W     = PROJ_W - 16;
    localparam int COEF_W   = 16;
    localparam int ROWP_W   = COEF_W + PX_W;
    localparam int ACC_W    = 64;
    localparam int SUM_W    = ACC_W - 28;
    localparam int POINT_W  = 32;
    localparam int ROW_W    = 64;
    localparam int NUM_ROWS = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z       = 3'd4;

    // reset rows give the identity transform
    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0;

    // rotator start vector, gain already folded in (Q1.30)
    localparam logic signed [XY_W-1:0] TRIG_GAIN = 33'sd652032874;

    // atan(2^-i) in 1/2^32 turn
    localparam logic [31:0] ATAN_TURN [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [ANGLE_W-1:0]                start_angle;
        logic [ANGLE_W-1:0]                angle_step;
        logic [NUM_ROWS-1:0][ROW_W-1:0]    row;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [ANGLE_W-1:0] angle;
    } angle_item_t;

    typedef struct packed {
        logic [RANGE_W-1:0]     range_mm;
        logic [1:0]             quad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
    } cordic_item_t;

endpackage

// ===== design/pstp_if.sv =====
// sample channel
interface pstp_in_if
    import pstp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [RANGE_W-1:0]    range_mm;
    logic                  range_valid;
    logic [INDEX_BITS-1:0] sample_index;

    modport source (output valid, range_mm, range_valid, sample_index, input ready);
    modport sink   (input valid, range_mm, range_valid, sample_index, output ready);
endinterface

// point channel
interface pstp_out_if
    import pstp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
    logic [POINT_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== design/pstp_cfg_regs.sv =====
module pstp_cfg_regs
    import pstp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // write decode, unused indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_ANGLE: cfg_next.start_angle = cfg_wdata[ANGLE_W-1:0];
                CFG_ANGLE_STEP:  cfg_next.angle_step  = cfg_wdata[ANGLE_W-1:0];
                CFG_ROW_X:       cfg_next.row[0]      = cfg_wdata[ROW_W-1:0];
                CFG_ROW_Y:       cfg_next.row[1]      = cfg_wdata[ROW_W-1:0];
                CFG_ROW_Z:       cfg_next.row[2]      = cfg_wdata[ROW_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle <= '0;
            cfg_reg.angle_step  <= '0;
            cfg_reg.row[0]      <= ROW_X_RESET;
            cfg_reg.row[1]      <= ROW_Y_RESET;
            cfg_reg.row[2]      <= ROW_Z_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pstp_angle.sv =====
`include "polar_scan_to_transformed_point_macros.svh"

module pstp_angle
    import pstp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    pstp_in_if.sink     sample,
    input  logic        down_ready,
    output logic        item_valid,
    output angle_item_t item
);

    logic                          valid_reg;
    logic                          valid_next;
    angle_item_t                   item_reg;
    angle_item_t                   item_next;
    logic [INDEX_BITS+ANGLE_W-1:0] step_prod;
    logic                          load;

    // stage takes a new item when empty or when its item moves on
    assign load         = !valid_reg || down_ready;
    assign sample.ready = load;

    // beam angle, wraps modulo one turn; invalid ranges are dropped here
    always_comb
    begin
        step_prod          = sample.sample_index * cfg.angle_step;
        item_next.range_mm = sample.range_mm;
        item_next.angle    = cfg.start_angle + step_prod[ANGLE_W-1:0];
        valid_next         = sample.valid && sample.range_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    `PSTP_ASSERT_NEXT(a_drop_invalid, clk, rst_n, sample.valid && sample.ready && !sample.range_valid, !valid_reg, "invalid range reached the angle stage")
    `PSTP_ASSERT_NEXT(a_hold_stalled, clk, rst_n, valid_reg && !down_ready, valid_reg && $stable(item_reg), "stalled angle item lost")

endmodule

// ===== design/pstp_cordic.sv =====
module pstp_cordic
    import pstp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    input  angle_item_t  up_item,
    output logic         up_ready,
    input  logic         down_ready,
    output logic         item_valid,
    output cordic_item_t item
);

    logic [CORDIC_ITERS-1:0] valid_reg;
    logic [CORDIC_ITERS:0]   ready;
    cordic_item_t            item_reg  [CORDIC_ITERS];
    cordic_item_t            item_next [CORDIC_ITERS];
    logic [CORDIC_ITERS-1:0] valid_in;
    cordic_item_t            item_in   [CORDIC_ITERS];
    cordic_item_t            seed;

    // start vector on the quarter-turn residue, quadrant rides along
    always_comb
    begin
        seed.range_mm = up_item.range_mm;
        seed.quad     = up_item.angle[ANGLE_W-1:ANGLE_W-2];
        seed.x        = TRIG_GAIN;
        seed.y        = '0;
        seed.z        = XY_W'({up_item.angle[ANGLE_W-3:0], 16'h0000});
    end

    assign ready[CORDIC_ITERS] = down_ready;
    assign up_ready            = ready[0];

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            assign valid_in[i] = up_valid;
            assign item_in[i]  = seed;
        end
        else
        begin : g_rest
            assign valid_in[i] = valid_reg[i-1];
            assign item_in[i]  = item_reg[i-1];
        end

        assign ready[i] = !valid_reg[i] || ready[i+1];

        // one micro-rotation, direction from the sign of the residual angle
        always_comb
        begin
            item_next[i] = item_in[i];
            if (!item_in[i].z[XY_W-1])
            begin
                item_next[i].x = item_in[i].x - (item_in[i].y >>> i);
                item_next[i].y = item_in[i].y + (item_in[i].x >>> i);
                item_next[i].z = item_in[i].z - XY_W'(ATAN_TURN[i]);
            end
            else
            begin
                item_next[i].x = item_in[i].x + (item_in[i].y >>> i);
                item_next[i].y = item_in[i].y - (item_in[i].x >>> i);
                item_next[i].z = item_in[i].z + XY_W'(ATAN_TURN[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (ready[i])
            begin
                valid_reg[i] <= valid_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[i])
            begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign item_valid = valid_reg[CORDIC_ITERS-1];
    assign item       = item_reg[CORDIC_ITERS-1];

endmodule

// ===== design/pstp_transform.sv =====
module pstp_transform
    import pstp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         up_valid,
    input  cordic_item_t up_item,
    output logic         up_ready,
    pstp_out_if.source   point
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // stage valids and moves
    logic valid_p_reg, valid_m_reg, valid_s_reg, valid_o_reg;
    logic ready_p, ready_m, ready_s, ready_o;

    // projection stage
    logic signed [XY_W-1:0]   cos_val, sin_val;
    logic signed [PROJ_W-1:0] proj_x, proj_y;
    logic [PROJ_W-1:0]        proj_x_rnd, proj_y_rnd;
    logic signed [PX_W-1:0]   px_reg, py_reg, px_next, py_next;

    // row products, sums and saturated outputs
    logic [NUM_ROWS-1:0][ROWP_W-1:0]  pa_reg, pb_reg, pa_next, pb_next;
    logic [NUM_ROWS-1:0][SUM_W-1:0]   sum_reg, sum_next;
    logic [NUM_ROWS-1:0][POINT_W-1:0] pt_reg, pt_next;

    assign ready_o  = !valid_o_reg || point.ready;
    assign ready_s  = !valid_s_reg || ready_o;
    assign ready_m  = !valid_m_reg || ready_s;
    assign ready_p  = !valid_p_reg || ready_m;
    assign up_ready = ready_p;

    // rotate back by quadrant, then scale by range with rounding to mm * 2^14
    always_comb
    begin
        case (up_item.quad)
            QUAD_0:
            begin
                cos_val = up_item.x;
                sin_val = up_item.y;
            end
            QUAD_1:
            begin
                cos_val = -up_item.y;
                sin_val = up_item.x;
            end
            QUAD_2:
            begin
                cos_val = -up_item.x;
                sin_val = -up_item.y;
            end
            default:
            begin
                cos_val = up_item.y;
                sin_val = -up_item.x;
            end
        endcase
        proj_x     = $signed({1'b0, up_item.range_mm}) * cos_val;
        proj_y     = $signed({1'b0, up_item.range_mm}) * sin_val;
        proj_x_rnd = proj_x + PROJ_W'(32768);
        proj_y_rnd = proj_y + PROJ_W'(32768);
        px_next    = proj_x_rnd[PROJ_W-1:16];
        py_next    = proj_y_rnd[PROJ_W-1:16];
    end

    // coefficient products, one pair per row
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            pa_next[r] = ROWP_W'($signed(cfg.row[r][15:0]) * px_reg);
            pb_next[r] = ROWP_W'($signed(cfg.row[r][31:16]) * py_reg);
        end
    end

    // accumulate with translation and rounding, drop 28 fraction bits
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            acc = ACC_W'($signed(pa_reg[r])) + ACC_W'($signed(pb_reg[r]))
                + (ACC_W'($signed(cfg.row[r][63:32])) <<< 28) + (ACC_W'(1) <<< 27);
            sum_next[r] = acc[ACC_W-1:28];
        end
    end

    // saturate to 32-bit signed
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (&sum_reg[r][SUM_W-1:POINT_W-1] || ~|sum_reg[r][SUM_W-1:POINT_W-1])
            begin
                pt_next[r] = sum_reg[r][POINT_W-1:0];
            end
            else if (sum_reg[r][SUM_W-1])
            begin
                pt_next[r] = 32'h8000_0000;
            end
            else
            begin
                pt_next[r] = 32'h7FFF_FFFF;
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_p_reg <= 1'b0;
            valid_m_reg <= 1'b0;
            valid_s_reg <= 1'b0;
            valid_o_reg <= 1'b0;
        end
        else
        begin
            if (ready_p)
            begin
                valid_p_reg <= up_valid;
            end
            if (ready_m)
            begin
                valid_m_reg <= valid_p_reg;
            end
            if (ready_s)
            begin
                valid_s_reg <= valid_m_reg;
            end
            if (ready_o)
            begin
                valid_o_reg <= valid_s_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (ready_p)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (ready_m)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (ready_s)
        begin
            sum_reg <= sum_next;
        end
        if (ready_o)
        begin
            pt_reg <= pt_next;
        end
    end

    assign point.valid   = valid_o_reg;
    assign point.point_x = pt_reg[0];
    assign point.point_y = pt_reg[1];
    assign point.point_z = pt_reg[2];

endmodule

// ===== design/polar_scan_to_transformed_point.sv =====
// Lidar sample to transformed Cartesian point.
// sample channel: range_mm, range_valid, sample_index; an item is taken when
// valid and ready are both high. Items with range_valid low are dropped and
// produce no point. point channel: point_x, point_y, point_z in signed mm.
// Configuration: cfg_we, cfg_index, cfg_wdata write start_angle, angle_step
// and the three transform rows; write only while the pipeline is empty.
// Registers in order: the beam angle, one per rotator stage, then projection,
// row products, row sums and the saturating output register.
// Throughput is one item per clock while the output is not stalled; every
// stage is a register with its own valid bit, so a new item enters each
// cycle unless back-pressure has filled the stages up to the input.
// When the receiver holds ready low the output register keeps its point and
// the stall moves back only through full stages; empty stages still fill.
// Reset empties the pipeline and loads the identity transform with zero
// start angle and step.
`include "polar_scan_to_transformed_point_macros.svh"

module polar_scan_to_transformed_point
    import pstp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    pstp_in_if.sink               sample,
    pstp_out_if.source            point
);

    cfg_t         cfg;
    logic         ang_valid;
    angle_item_t  ang_item;
    logic         ang_ready;
    logic         cor_valid;
    cordic_item_t cor_item;
    logic         cor_ready;

    pstp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pstp_angle u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample),
        .down_ready (ang_ready),
        .item_valid (ang_valid),
        .item       (ang_item)
    );

    pstp_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (ang_valid),
        .up_item    (ang_item),
        .up_ready   (ang_ready),
        .down_ready (cor_ready),
        .item_valid (cor_valid),
        .item       (cor_item)
    );

    pstp_transform u_transform (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (cor_valid),
        .up_item  (cor_item),
        .up_ready (cor_ready),
        .point    (point)
    );

    `PSTP_ASSERT_NOW(a_stall_source, clk, rst_n, !sample.ready, point.valid && !point.ready, "input stalled without output backpressure")
    `PSTP_ASSERT_NOW(a_flow_through, clk, rst_n, point.ready, sample.ready, "input not ready while output drains")
    `PSTP_ASSERT_NEXT(a_cfg_idle, clk, rst_n, cfg_we && cfg_index == CFG_ROW_X, cfg.row[0] == $past(cfg_wdata), "row x write not taken")

endmodule
